[rtl/core/atps_pkg.sv]
// ============================================================================
// atps_pkg
// Shared types, state codes, beep pattern tables and the sine table builder
// for the alert tone pattern sequencer.
// ============================================================================
`default_nettype none

package atps_pkg;

    localparam int unsigned SINE_DEPTH_DFLT = 256;

    localparam int unsigned TONE_W = 11;
    localparam int unsigned OPST_W = 5;
    localparam int unsigned FRAME_W = 16;

    // state codes
    localparam logic [OPST_W-1:0] SEQ_STATES   = 5'd13;
    localparam logic [OPST_W-1:0] ST_CRIT_BATT = 5'd13;
    localparam logic [OPST_W-1:0] ST_OBST_CRIT = 5'd14;
    localparam logic [OPST_W-1:0] ST_INTRUDER  = 5'd15;
    localparam logic [OPST_W-1:0] ST_GAS       = 5'd16;
    localparam logic [OPST_W-1:0] ST_ESTOP     = 5'd17;
    localparam logic [OPST_W-1:0] ST_NONE      = 5'd31;

    localparam logic [31:0] HOLD_MS = 32'd1000;
    localparam logic [2:0]  SEQ_MAX = 3'd5;

    // 0.3 rad in units of 2^-32 turn
    localparam logic [31:0] PHASE_STEP = 32'd205069583;

    localparam logic [TONE_W-1:0] SEQ_TONE [0:12][0:4] = '{
        '{11'd880,  11'd0, 11'd0,    11'd0, 11'd0},
        '{11'd1000, 11'd0, 11'd0,    11'd0, 11'd0},
        '{11'd600,  11'd0, 11'd0,    11'd0, 11'd0},
        '{11'd900,  11'd0, 11'd0,    11'd0, 11'd0},
        '{11'd784,  11'd0, 11'd0,    11'd0, 11'd0},
        '{11'd880,  11'd0, 11'd880,  11'd0, 11'd0},
        '{11'd440,  11'd0, 11'd440,  11'd0, 11'd0},
        '{11'd350,  11'd0, 11'd0,    11'd0, 11'd0},
        '{11'd1200, 11'd0, 11'd1200, 11'd0, 11'd1200},
        '{11'd1500, 11'd0, 11'd1500, 11'd0, 11'd1500},
        '{11'd440,  11'd0, 11'd0,    11'd0, 11'd0},
        '{11'd1000, 11'd0, 11'd0,    11'd0, 11'd0},
        '{11'd220,  11'd0, 11'd0,    11'd0, 11'd0}
    };

    localparam logic [9:0] SEQ_DUR [0:12][0:4] = '{
        '{10'd100, 10'd0,   10'd0,   10'd0,  10'd0},
        '{10'd150, 10'd0,   10'd0,   10'd0,  10'd0},
        '{10'd80,  10'd0,   10'd0,   10'd0,  10'd0},
        '{10'd100, 10'd0,   10'd0,   10'd0,  10'd0},
        '{10'd150, 10'd0,   10'd0,   10'd0,  10'd0},
        '{10'd80,  10'd80,  10'd80,  10'd0,  10'd0},
        '{10'd200, 10'd200, 10'd200, 10'd0,  10'd0},
        '{10'd600, 10'd0,   10'd0,   10'd0,  10'd0},
        '{10'd80,  10'd80,  10'd80,  10'd80, 10'd80},
        '{10'd60,  10'd60,  10'd60,  10'd60, 10'd60},
        '{10'd150, 10'd0,   10'd0,   10'd0,  10'd0},
        '{10'd100, 10'd0,   10'd0,   10'd0,  10'd0},
        '{10'd800, 10'd0,   10'd0,   10'd0,  10'd0}
    };

    localparam logic [2:0] SEQ_LEN [0:12] = '{
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd3, 3'd3, 3'd1, 3'd5, 3'd5, 3'd1, 3'd1, 3'd1
    };

    localparam logic [63:0] TAYLOR_DIV [0:5] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156
    };

    typedef enum logic [1:0] {
        SEL_DIRECT = 2'd0,
        SEL_SIREN  = 2'd1,
        SEL_HOLD   = 2'd2
    } t_tsel;

    typedef struct packed {
        t_tsel             sel;
        logic [TONE_W-1:0] val;
        logic              busy;
        logic              fin;
    } t_ctl;

    // Q30 sine of a 32-bit turn phase, evaluated at elaboration
    function automatic logic signed [31:0] sine_q30(input logic [31:0] phase32);
        logic [1:0]         quad;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        int                 k;
        quad = phase32[31:30];
        r    = {34'd0, phase32[29:0]};
        if (quad[0]) begin
            r = 64'h4000_0000 - r;
        end
        x    = (r * 64'd1686629713) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
            if ((k % 2) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum > 64'sd1073741824) begin
            sum = 64'sd1073741824;
        end
        if (sum < 64'sd0) begin
            sum = 64'sd0;
        end
        return quad[1] ? -sum[31:0] : sum[31:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/atps_ctrl.sv]
// ============================================================================
// atps_ctrl
// Per-tick state tracking: state change detect, elapsed counters, beep
// segment walk and tone source selection for each accepted item.
// ============================================================================
`default_nettype none

module atps_ctrl (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_acc,
    input  wire  [atps_pkg::OPST_W-1:0]      i_op_state,
    output atps_pkg::t_ctl                   o_ctl
);
    import atps_pkg::*;

    logic [OPST_W-1:0] r_last, n_last;
    logic [31:0]       r_elapsed, n_elapsed;
    logic [2:0]        r_idx, n_idx;
    logic [9:0]        r_time, n_time;
    logic              r_act, n_act;
    logic [10:0]       r_c1500, n_c1500;
    logic [8:0]        r_c300, n_c300;
    logic [7:0]        r_c200, n_c200;

    logic              w_chg;
    logic              w_clr;
    logic              w_act;
    logic [31:0]       w_e;
    logic [2:0]        w_idx;
    logic [2:0]        w_ix;
    logic [9:0]        w_time;
    logic [9:0]        w_t1;
    logic [3:0]        w_nx;
    logic [3:0]        w_st;
    logic [10:0]       w_c1500;
    logic [8:0]        w_c300;
    logic [7:0]        w_c200;
    logic              w_wrap;

    always_comb begin
        w_chg   = (i_op_state != r_last);
        w_clr   = w_chg && r_act;
        w_act   = w_chg ? (i_op_state < SEQ_STATES) : r_act;
        w_e     = w_chg ? 32'd0 : r_elapsed;
        w_idx   = w_chg ? 3'd0 : r_idx;
        w_time  = w_chg ? 10'd0 : r_time;
        w_c1500 = w_chg ? 11'd0 : r_c1500;
        w_c300  = w_chg ? 9'd0 : r_c300;
        w_c200  = w_chg ? 8'd0 : r_c200;
        w_ix    = (w_idx >= SEQ_MAX) ? (w_idx - SEQ_MAX) : w_idx;
        w_st    = i_op_state[3:0];
        w_t1    = w_time + 10'd1;
        w_nx    = {1'b0, w_ix} + 4'd1;

        o_ctl   = '{sel: SEL_DIRECT, val: '0, busy: 1'b0, fin: 1'b0};
        n_last  = i_op_state;
        n_idx   = w_idx;
        n_time  = w_time;
        n_act   = w_act;

        if (w_act) begin
            o_ctl.val  = SEQ_TONE[w_st][w_ix];
            o_ctl.busy = 1'b1;
            if (w_t1 >= SEQ_DUR[w_st][w_ix]) begin
                n_time = 10'd0;
                if (w_nx >= {1'b0, SEQ_LEN[w_st]}) begin
                    n_act     = 1'b0;
                    n_idx     = 3'd0;
                    o_ctl.fin = 1'b1;
                end else begin
                    n_idx = w_nx[2:0];
                end
            end else begin
                n_time = w_t1;
            end
        end else begin
            n_act = 1'b0;
            case (i_op_state)
                ST_CRIT_BATT: o_ctl.val = (w_c1500 < 11'd150) ? 11'd500 : 11'd0;
                ST_OBST_CRIT: o_ctl.val = (w_c300 < 9'd100) ? 11'd1200 : 11'd0;
                ST_INTRUDER,
                ST_GAS:       o_ctl.sel = SEL_SIREN;
                ST_ESTOP:     o_ctl.val = (w_c200 < 8'd100) ? 11'd2000 : 11'd1500;
                default: begin
                    if (!(w_e > HOLD_MS) && !w_clr) begin
                        o_ctl.sel = SEL_HOLD;
                    end
                end
            endcase
        end

        // modulo counters restart with the elapsed count when it wraps
        w_wrap    = &w_e;
        n_elapsed = w_e + 32'd1;
        n_c1500   = (w_wrap || w_c1500 == 11'd1499) ? 11'd0 : w_c1500 + 11'd1;
        n_c300    = (w_wrap || w_c300 == 9'd299) ? 9'd0 : w_c300 + 9'd1;
        n_c200    = (w_wrap || w_c200 == 8'd199) ? 8'd0 : w_c200 + 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= ST_NONE;
            r_elapsed <= '0;
            r_idx     <= '0;
            r_time    <= '0;
            r_act     <= 1'b0;
            r_c1500   <= '0;
            r_c300    <= '0;
            r_c200    <= '0;
        end else if (i_acc) begin
            r_last    <= n_last;
            r_elapsed <= n_elapsed;
            r_idx     <= n_idx;
            r_time    <= n_time;
            r_act     <= n_act;
            r_c1500   <= n_c1500;
            r_c300    <= n_c300;
            r_c200    <= n_c200;
        end
    end

endmodule

`default_nettype wire

[rtl/core/atps_sine_rom.sv]
// ============================================================================
// atps_sine_rom
// One-turn Q30 sine table with a registered read of two neighboring samples.
// ============================================================================
`default_nettype none

module atps_sine_rom #(
    parameter int unsigned SINE_TABLE_DEPTH = atps_pkg::SINE_DEPTH_DFLT
) (
    input  wire                                   i_clk,
    input  wire                                   i_en,
    input  wire  [$clog2(SINE_TABLE_DEPTH)-1:0]   i_idx,
    output logic signed [31:0]                    o_lo,
    output logic signed [31:0]                    o_hi
);
    import atps_pkg::*;

    logic signed [31:0] w_lo [SINE_TABLE_DEPTH];
    logic signed [31:0] w_hi [SINE_TABLE_DEPTH];

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_tab
        localparam logic [63:0] PH_LO = (64'(g) << 32) / 64'(SINE_TABLE_DEPTH);
        localparam logic [63:0] PH_HI = (64'(g + 1) << 32) / 64'(SINE_TABLE_DEPTH);
        assign w_lo[g] = sine_q30(PH_LO[31:0]);
        assign w_hi[g] = sine_q30(PH_HI[31:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lo <= w_lo[i_idx];
            o_hi <= w_hi[i_idx];
        end
    end

endmodule

`default_nettype wire

[rtl/core/atps_siren.sv]
// ============================================================================
// atps_siren
// Four-stage siren pipeline: phase, table index, sample read, interpolation.
// Carries each item's control word alongside.
// ============================================================================
`default_nettype none

module atps_siren #(
    parameter int unsigned SINE_TABLE_DEPTH = atps_pkg::SINE_DEPTH_DFLT
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_ld,
    input  wire  [atps_pkg::FRAME_W-1:0]     i_frame,
    input  wire  atps_pkg::t_ctl             i_ctl,
    output logic                             o_rdy,
    input  wire                              i_rdy_out,
    output logic                             o_vld,
    output atps_pkg::t_ctl                   o_ctl,
    output logic signed [31:0]               o_sine
);
    import atps_pkg::*;

    localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned PW = 16 + IW;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic w_ld2, w_ld3, w_ld4;

    t_ctl               r_ctl1, r_ctl2, r_ctl3, r_ctl4;
    logic [15:0]        r_phase1;
    logic [IW-1:0]      r_idx2;
    logic [15:0]        r_frac2, r_frac3;
    logic signed [31:0] w_a3, w_b3;
    logic signed [31:0] r_s4;

    logic [31:0]        w_pprod;
    logic [PW-1:0]      w_pidx;
    logic signed [32:0] w_diff;
    logic signed [49:0] w_prod;
    logic signed [49:0] w_q;

    assign w_rdy4 = !r_v4 || i_rdy_out;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_ld2  = r_v1 && w_rdy2;
    assign w_ld3  = r_v2 && w_rdy3;
    assign w_ld4  = r_v3 && w_rdy4;
    assign o_rdy  = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_ld  || (r_v1 && !w_rdy2);
            r_v2 <= w_ld2 || (r_v2 && !w_rdy3);
            r_v3 <= w_ld3 || (r_v3 && !w_rdy4);
            r_v4 <= w_ld4 || (r_v4 && !i_rdy_out);
        end
    end

    assign w_pprod = 32'(i_frame) * PHASE_STEP;
    assign w_pidx  = PW'(r_phase1) * PW'(SINE_TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_ctl1   <= i_ctl;
            r_phase1 <= w_pprod[31:16];
        end
        if (w_ld2) begin
            r_ctl2  <= r_ctl1;
            r_idx2  <= w_pidx[PW-1:16];
            r_frac2 <= w_pidx[15:0];
        end
        if (w_ld3) begin
            r_ctl3  <= r_ctl2;
            r_frac3 <= r_frac2;
        end
        if (w_ld4) begin
            r_ctl4 <= r_ctl3;
            r_s4   <= w_a3 + w_q[31:0];
        end
    end

    atps_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk (i_clk),
        .i_en  (w_ld3),
        .i_idx (r_idx2),
        .o_lo  (w_a3),
        .o_hi  (w_b3)
    );

    // interpolation step, quotient truncated toward zero
    always_comb begin
        w_diff = 33'(w_b3) - 33'(w_a3);
        w_prod = 50'(w_diff) * 50'($signed({1'b0, r_frac3}));
        w_q    = w_prod[49] ? ((w_prod + 50'sd65535) >>> 16) : (w_prod >>> 16);
    end

    assign o_vld  = r_v4;
    assign o_ctl  = r_ctl4;
    assign o_sine = r_s4;

endmodule

`default_nettype wire

[rtl/core/alert_tone_pattern_sequencer.sv]
// ============================================================================
// alert_tone_pattern_sequencer
// Buzzer tone sequencer: one millisecond tick in, one tone item out.
// ============================================================================
// Takes one tick item per clock while s_axis_tready is high and returns one
// tone item per tick, in order; each item passes through the siren pipeline
// (phase, table index, sample read, interpolation) and then the output
// register, and every stage moves on its own so bubbles close up under
// backpressure. The sine table is built at elaboration, so no initialization
// pass follows reset.
`default_nettype none

module alert_tone_pattern_sequencer #(
    parameter int unsigned SINE_TABLE_DEPTH = atps_pkg::SINE_DEPTH_DFLT
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // [4:0] op_state, [20:5] frame
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata    // [10:0] tone_hz, [11] sequence_busy
);
    import atps_pkg::*;

    localparam logic signed [42:0] SIREN_BASE = 43'sd858993459200;
    localparam logic [12:0]        TONE_MAX   = 13'd2000;

    logic               w_acc;
    t_ctl               w_ctl_in;
    t_ctl               w_ctl;
    logic               w_vld;
    logic signed [31:0] w_sine;
    logic               w_rdy_out;
    logic               w_ld_out;

    logic signed [42:0] w_sx;
    logic signed [42:0] w_f;
    logic [12:0]        w_hz;
    logic [TONE_W-1:0]  w_siren;
    logic [TONE_W-1:0]  w_tone;

    logic               r_ov;
    logic [TONE_W-1:0]  r_tone;
    logic               r_busy;
    logic [TONE_W-1:0]  r_held;

    assign w_acc     = s_axis_tvalid && s_axis_tready;
    assign w_rdy_out = !r_ov || m_axis_tready;
    assign w_ld_out  = w_vld && w_rdy_out;

    atps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (w_acc),
        .i_op_state (s_axis_tdata[4:0]),
        .o_ctl      (w_ctl_in)
    );

    atps_siren #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_siren (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ld      (w_acc),
        .i_frame   (s_axis_tdata[20:5]),
        .i_ctl     (w_ctl_in),
        .o_rdy     (s_axis_tready),
        .i_rdy_out (w_rdy_out),
        .o_vld     (w_vld),
        .o_ctl     (w_ctl),
        .o_sine    (w_sine)
    );

    // 800 + 400 * sine, floor of the Q30 result
    always_comb begin
        w_sx    = 43'(w_sine);
        w_f     = SIREN_BASE + (w_sx <<< 8) + (w_sx <<< 7) + (w_sx <<< 4);
        w_hz    = w_f[42:30];
        w_siren = (w_hz > TONE_MAX) ? TONE_MAX[TONE_W-1:0] : w_hz[TONE_W-1:0];
        case (w_ctl.sel)
            SEL_DIRECT: w_tone = w_ctl.val;
            SEL_SIREN:  w_tone = w_siren;
            SEL_HOLD:   w_tone = r_held;
            default:    w_tone = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_held <= '0;
        end else begin
            r_ov <= w_ld_out || (r_ov && !m_axis_tready);
            if (w_ld_out) begin
                r_held <= w_ctl.fin ? '0 : w_tone;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_out) begin
            r_tone <= w_tone;
            r_busy <= w_ctl.busy;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {4'd0, r_busy, r_tone};

endmodule

`default_nettype wire

[rtl/core/atps_checker.sv]
// ============================================================================
// atps_checker
// Port-level checks on the tone sequencer: output hold, encoding, and item
// balance between the two sides.
// ============================================================================
`default_nettype none

module atps_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire [23:0] s_axis_tdata,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata
);
    import atps_pkg::*;

    logic [2:0] r_cnt;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 3'(w_in_acc) - 3'(w_out_acc);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_tone_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[10:0] <= 11'd2000 && m_axis_tdata[15:12] == 4'd0)
        else $error("tone item out of range or padding set");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_cnt != 3'd0)
        else $error("output item without accepted tick");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd5)
        else $error("more items in flight than pipeline holds");

    a_s_data_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && s_axis_tdata[4:0] == ST_INTRUDER |-> ##5 !(r_cnt > 3'd5))
        else $error("pipeline overfilled after siren tick");

endmodule

bind alert_tone_pattern_sequencer atps_checker u_atps_checker (.*);

`default_nettype wire
